// ----- design/wsp_pkg.sv -----
package wsp_pkg;

  localparam int SCREEN_W_DEF = 1280;
  localparam int SCREEN_H_DEF = 720;
  localparam int FRAC = 16;
  localparam int NUM_REGS = 8;
  localparam int ADDR_W = 6;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } req_t;

  typedef struct packed {
    logic        visible;
    logic [26:0] screen_x;
    logic [25:0] screen_y;
  } res_t;

endpackage

// ----- design/wsp_div.sv -----
module wsp_div #(
  parameter int HALF = wsp_pkg::SCREEN_W_DEF / 2,
  parameter int QW = 27
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic          in_flag,
  input  logic [32:0]   num,
  input  logic [31:0]   den,
  output logic          out_vld,
  output logic          out_flag,
  output logic [QW-1:0] quo
);
  localparam int HW = $clog2(HALF + 1);
  localparam int DW = 33 + HW + wsp_pkg::FRAC;
  localparam int EW = DW + 33;

  logic          vld  [QW+1];
  logic          flag [QW+1];
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [31:0]   dv   [QW+1];

  // scale numerator into the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    flag[0] <= in_flag;
    rem[0]  <= DW'(num * HW'(HALF)) << wsp_pkg::FRAC;
    q[0]    <= '0;
    dv[0]   <= den;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [EW-1:0] sub;
    logic [EW-1:0] trial;
    assign sub   = EW'(dv[k]) << SH;
    assign trial = EW'(rem[k]) - sub;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      flag[k+1] <= flag[k];
      dv[k+1]   <= dv[k];
      if (EW'(rem[k]) >= sub) begin
        rem[k+1] <= trial[DW-1:0];
        q[k+1]   <= q[k] | (QW'(1) << SH);
      end else begin
        rem[k+1] <= rem[k];
        q[k+1]   <= q[k];
      end
    end
  end

  assign out_vld  = vld[QW];
  assign out_flag = flag[QW];
  assign quo      = q[QW];
endmodule

// ----- design/world_to_screen_projection.sv -----
// Projects one world point per cycle; busy is never raised.
// Each request passes the matrix multiply, sum, clip check and scale registers,
// then one divider stage per quotient bit and the result register before done.
// Throughput: one request per cycle.
// Reset (rst, synchronous) clears the matrix registers and all valid bits;
// the receiver cannot stall, so results are never held.
module world_to_screen_projection #(
  parameter int SCREEN_W = wsp_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = wsp_pkg::SCREEN_H_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  wsp_pkg::req_t                req,
  output logic                         done,
  output wsp_pkg::res_t                res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  localparam int HALF_X = SCREEN_W / 2;
  localparam int HALF_Y = SCREEN_H / 2;
  localparam int HMAX = (HALF_X > HALF_Y) ? HALF_X : HALF_Y;
  localparam int QW = $clog2(2 * HMAX * 65536 + 1);
  localparam int LAT = QW + 5;
  localparam int CLW = 51;
  localparam int NUMW = 53;
  localparam logic [QW:0] LIM_X = (QW + 1)'(SCREEN_W * 65536);
  localparam logic [QW:0] LIM_Y = (QW + 1)'(SCREEN_H * 65536);

  logic [63:0] regs [wsp_pkg::NUM_REGS];
  logic [2:0]  ridx;

  assign ridx   = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = regs[ridx];
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wsp_pkg::NUM_REGS; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite) begin
      regs[ridx] <= pwdata;
    end
  end

  logic signed [31:0] m [4][4];
  logic signed [31:0] p [3];
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = (c % 2 == 1) ? $signed(regs[r*2 + c/2][63:32])
                                    : $signed(regs[r*2 + c/2][31:0]);
    end
  end
  assign p[0] = req.world_x;
  assign p[1] = req.world_y;
  assign p[2] = req.world_z;

  // stage 1: products
  logic               s1_vld;
  logic signed [63:0] prod [3][4];
  logic signed [31:0] s1_tr [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) prod[i][j] <= p[i] * m[i][j];
      s1_tr[j] <= m[3][j];
    end
  end

  // stage 2: floor each product to Q16.16 and sum
  logic                 s2_vld;
  logic signed [CLW-1:0] clip [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    for (int j = 0; j < 4; j++) begin
      clip[j] <= CLW'($signed(prod[0][j][63:16])) + CLW'($signed(prod[1][j][63:16]))
               + CLW'($signed(prod[2][j][63:16])) + CLW'(s1_tr[j]);
    end
  end

  // stage 3: clip checks and sign folding
  logic signed [NUMW-1:0] cw, wa, nx0, ny0, nx, ny;
  logic                   wok, neg, okx, oky;
  always_comb begin
    cw  = NUMW'(clip[3]);
    neg = cw < 0;
    wa  = neg ? -cw : cw;
    nx0 = NUMW'(clip[0]) + cw;
    ny0 = cw - NUMW'(clip[1]);
    nx  = neg ? -nx0 : nx0;
    ny  = neg ? -ny0 : ny0;
    wok = (cw != 0) && (cw >= -NUMW'(64'sh80000000)) && (cw <= NUMW'(64'sh7FFFFFFF))
          && (clip[2] >= 0);
    okx = (nx >= 0) && (nx <= (wa <<< 1));
    oky = (ny >= 0) && (ny <= (wa <<< 1));
  end

  logic        s3_vld, s3_flag;
  logic [32:0] s3_nx, s3_ny;
  logic [31:0] s3_w;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    s3_flag <= wok && okx && oky;
    s3_nx   <= nx[32:0];
    s3_ny   <= ny[32:0];
    s3_w    <= wa[31:0];
  end

  logic          dx_vld, dx_flag, dy_vld, dy_flag;
  logic [QW-1:0] qx, qy;

  wsp_div #(.HALF(HALF_X), .QW(QW)) u_div_x (
    .clk(clk), .rst(rst), .in_vld(s3_vld), .in_flag(s3_flag),
    .num(s3_nx), .den(s3_w), .out_vld(dx_vld), .out_flag(dx_flag), .quo(qx)
  );

  wsp_div #(.HALF(HALF_Y), .QW(QW)) u_div_y (
    .clk(clk), .rst(rst), .in_vld(s3_vld), .in_flag(s3_flag),
    .num(s3_ny), .den(s3_w), .out_vld(dy_vld), .out_flag(dy_flag), .quo(qy)
  );

  logic vis;
  assign vis = dx_flag && dy_flag && (qx != '0) && ((QW + 1)'(qx) < LIM_X)
               && (qy != '0) && ((QW + 1)'(qy) < LIM_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dx_vld && dy_vld;
    end
    res.visible  <= vis;
    res.screen_x <= vis ? 27'(qx) : '0;
    res.screen_y <= vis ? 26'(qy) : '0;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done) else $error("request lost in pipeline");
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !res.visible) |-> (res.screen_x == '0 && res.screen_y == '0))
    else $error("hidden point has nonzero coordinates");
  a_visible_inside: assert property (@(posedge clk) disable iff (rst)
    (done && res.visible) |-> (res.screen_x != '0 && res.screen_y != '0))
    else $error("visible point on screen edge");
`endif
endmodule

// ----- tb/sv/world_to_screen_projection_tb.sv -----
`timescale 1ns / 100ps

module world_to_screen_projection_tb;

  localparam int HALF_W = wsp_pkg::SCREEN_W_DEF / 2;
  localparam int HALF_H = wsp_pkg::SCREEN_H_DEF / 2;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  wsp_pkg::req_t req = '0;
  logic done;
  wsp_pkg::res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [wsp_pkg::ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  logic signed [31:0] view_proj [4][4];
  wsp_pkg::res_t projections [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  int idle_pct_list [3] = '{0, 85, 29};

  world_to_screen_projection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Map num/w onto [0, 2*half] pixels in Q16.16; false when off range.
  function automatic bit scale_to_screen(logic signed [63:0] num, logic signed [63:0] w,
                                         int half, output logic [63:0] pix);
    logic [63:0] un;
    logic [63:0] uw;
    pix = '0;
    if (w < 0) begin
      w = -w;
      num = -num;
    end
    if (num < 0 || num > 2 * w) return 1'b0;
    un = num;
    uw = w;
    pix = (un * 64'(half) * 64'd65536) / uw;
    return 1'b1;
  endfunction

  function automatic wsp_pkg::res_t project_point(wsp_pkg::req_t p);
    logic signed [63:0] pt [3];
    logic signed [63:0] clip [4];
    logic signed [63:0] acc;
    logic signed [63:0] elem;
    logic [63:0] sx;
    logic [63:0] sy;
    bit vis;
    wsp_pkg::res_t r;
    pt[0] = p.world_x;
    pt[1] = p.world_y;
    pt[2] = p.world_z;
    for (int j = 0; j < 4; j++) begin
      acc = view_proj[3][j];
      for (int i = 0; i < 3; i++) begin
        elem = view_proj[i][j];
        acc += (pt[i] * elem) >>> 16;
      end
      clip[j] = acc;
    end
    sx = '0;
    sy = '0;
    vis = clip[3] != 0 && clip[3] >= -64'sh8000_0000 && clip[3] <= 64'sh7FFF_FFFF &&
          clip[2] >= 0;
    if (vis) vis = scale_to_screen(clip[0] + clip[3], clip[3], HALF_W, sx);
    if (vis) vis = scale_to_screen(clip[3] - clip[1], clip[3], HALF_H, sy);
    if (vis) vis = sx > 0 && sx < 64'(wsp_pkg::SCREEN_W_DEF) * 65536 &&
                   sy > 0 && sy < 64'(wsp_pkg::SCREEN_H_DEF) * 65536;
    if (!vis) begin
      sx = '0;
      sy = '0;
    end
    r.visible = vis;
    r.screen_x = sx[26:0];
    r.screen_y = sy[25:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    wsp_pkg::res_t want;
    if (!rst) begin
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
      if (done) begin
        if (projections.size() == 0) begin
          report_mismatch("unexpected done", 1, 0);
        end else begin
          want = projections.pop_front();
          if (res.visible !== want.visible) report_mismatch("visible", res.visible, want.visible);
          if (res.screen_x !== want.screen_x)
            report_mismatch("screen_x", res.screen_x, want.screen_x);
          if (res.screen_y !== want.screen_y)
            report_mismatch("screen_y", res.screen_y, want.screen_y);
        end
      end
    end
  end

  task automatic write_reg(int idx, logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= wsp_pkg::ADDR_W'(8 * idx);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    view_proj[idx / 2][(idx % 2) * 2] = data[31:0];
    view_proj[idx / 2][(idx % 2) * 2 + 1] = data[63:32];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_matrix(logic signed [31:0] m [4][4]);
    for (int k = 0; k < wsp_pkg::NUM_REGS; k++)
      write_reg(k, {m[k / 2][(k % 2) * 2 + 1], m[k / 2][(k % 2) * 2]});
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    req <= '{world_x: x, world_y: y, world_z: z};
    do @(posedge clk); while (busy);
    projections.push_back(project_point(req));
  endtask

  // Lower start, wait out every pending result and the pipeline tail.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (projections.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic perspective_matrix(output logic signed [31:0] m [4][4]);
    foreach (m[r, c]) m[r][c] = '0;
    m[0][0] = ONE;
    m[1][1] = ONE;
    m[2][2] = ONE;
    m[2][3] = ONE;
  endtask

  // Mostly points inside the view cone, some full random noise.
  task automatic send_random_points(int count);
    logic signed [31:0] z;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 8) begin
        z = $urandom_range(ONE / 4, 2000 * ONE);
        if ($urandom_range(0, 19) == 0) z = -z;
        send_point(32'((longint'($urandom_range(0, 2200)) - 1100) * z / 1000),
                   $signed($urandom_range(0, 2 * z)) - z, z);
      end else begin
        send_point($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_reset_matrix();
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -1);
    send_point(ONE, ONE, ONE);
    drain();
  endtask

  task automatic test_directed();
    logic signed [31:0] m [4][4];
    perspective_matrix(m);
    load_matrix(m);
    send_point(0, 0, ONE);                    // screen center
    send_point(ONE / 2, -ONE / 2, ONE);
    send_point(ONE, 0, ONE);                  // right edge
    send_point(-ONE, 0, ONE);                 // left edge
    send_point(0, ONE, ONE);                  // top edge
    send_point(0, -ONE, ONE);                 // bottom edge
    send_point(ONE - 1, -(ONE - 1), ONE);
    send_point(2 * ONE, 0, ONE);              // off screen
    send_point(0, 0, 0);                      // zero w
    send_point(0, 0, -ONE);                   // behind camera
    send_point(-ONE / 4, ONE / 4, -ONE);      // behind camera, negative w
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(1, -1, 1);
    drain();
    // Overflowing w: both w terms near the top of the range.
    m[2][3] = 32'sh7FFF_FFFF;
    m[3][3] = 32'sh7FFF_FFFF;
    load_matrix(m);
    send_point(0, 0, ONE);
    send_point(0, 0, 32'sh7FFF_FFFF);
    send_point(0, 0, -ONE);
    drain();
    foreach (m[r, c]) m[r][c] = (r + c) % 2 ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    load_matrix(m);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(-1, -1, -1);
    send_point(1, 0, 0);
    drain();
  endtask

  task automatic test_random_matrix();
    logic signed [31:0] m [4][4];
    foreach (m[r, c]) m[r][c] = $signed($urandom_range(0, ONE / 4)) - ONE / 8;
    for (int k = 0; k < 3; k++) m[k][k] = $urandom_range(ONE / 2, 2 * ONE);
    m[2][3] = $urandom_range(ONE / 2, 2 * ONE);
    load_matrix(m);
    send_random_points(200);
    drain();
  endtask

  task automatic test_perspective_random();
    logic signed [31:0] m [4][4];
    perspective_matrix(m);
    load_matrix(m);
    send_random_points(200);
    drain();
  endtask

  initial begin
    foreach (view_proj[r, c]) view_proj[r][c] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_matrix();
    test_directed();
    foreach (idle_pct_list[k]) begin
      idle_pct = idle_pct_list[k];
      test_perspective_random();
      test_random_matrix();
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
